[rtl/bdqs_pkg.sv]
// Package for the bounded deque with search: operation and status codes,
// payload widths and the command bundle broadcast to the cell row.
// No dependencies.
package bdqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;

	// Operation codes carried in func
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL_DROP = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd2;

	// Command seen by every cell in the cycle an item is accepted
	typedef struct packed {
		logic               en;
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
	} cmd_t;

endpackage

[rtl/bdqs_cell.sv]
// One storage cell of the deque row: holds one entry and its occupied flag,
// shifts toward the back on push front, and compares its entry on search.
// Depends on bdqs_pkg.
module bdqs_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bdqs_pkg::cmd_t               cmd,
	input  logic [bdqs_pkg::VALUE_W-1:0] prev_data,
	input  logic                         prev_occ,
	input  logic                         next_occ,
	output logic [bdqs_pkg::VALUE_W-1:0] data,
	output logic                         occ,
	output logic                         hit
);

	logic [bdqs_pkg::VALUE_W-1:0] data_q;
	logic                         occ_q;
	logic                         hit_q;

	// Occupied flags form a thermometer from the front cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.en) begin
			case (cmd.func)
				bdqs_pkg::FUNC_PUSH_FRONT: occ_q <= prev_occ;
				bdqs_pkg::FUNC_PUSH_BACK: begin
					if (!occ_q && prev_occ) occ_q <= 1'b1;
				end
				bdqs_pkg::FUNC_POP_BACK: begin
					if (occ_q && !next_occ) occ_q <= 1'b0;
				end
				default: hit_q <= occ_q && (data_q == cmd.value);
			endcase
		end
	end

	// Entry payload: take the neighbor's entry or the pushed value
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			case (cmd.func)
				bdqs_pkg::FUNC_PUSH_FRONT: data_q <= prev_data;
				bdqs_pkg::FUNC_PUSH_BACK: begin
					if (!occ_q && prev_occ) data_q <= cmd.value;
				end
				default: data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;
	assign occ  = occ_q;
	assign hit  = hit_q;

endmodule

[rtl/bounded_deque_with_search_unit.sv]
// Bounded deque with search: a row of DEPTH cells, front entry in cell 0.
// The cell row updates at the input accept edge and the hit reduction is registered when stage 1
// drains into the output register; one item per cycle while the result side is ready.
// A stage register and an output register sit between the two sides of the stream.
// Reset (arst_n low): deque empty, no result pending; entries are not cleared.
module bounded_deque_with_search_unit #(
	parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [0] found, [5:1] count, [6] is_empty, [8:7] status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [bdqs_pkg::FUNC_W-1:0]  func;
	logic [bdqs_pkg::VALUE_W-1:0] value;
	logic                         accept;
	logic                         full;
	logic                         empty;
	bdqs_pkg::cmd_t               cmd;
	logic [bdqs_pkg::STATUS_W-1:0] status_d;
	logic [CNT_W-1:0]             held_q;
	logic [CNT_W-1:0]             held_d;

	logic [DEPTH-1:0]             occ_vec;
	logic [DEPTH-1:0]             hit_vec;
	logic [bdqs_pkg::VALUE_W-1:0] data_vec [DEPTH];

	logic                          valid_s1;
	logic [bdqs_pkg::FUNC_W-1:0]   func_s1;
	logic [bdqs_pkg::STATUS_W-1:0] status_s1;
	logic [CNT_W-1:0]              count_s1;
	logic [bdqs_pkg::COUNT_W-1:0]  count5_s1;
	logic                          adv;

	logic                          m_valid_q;
	logic                          found_q;
	logic [bdqs_pkg::COUNT_W-1:0]  count_q;
	logic                          empty_q;
	logic [bdqs_pkg::STATUS_W-1:0] status_q;

	assign func   = s_tuser;
	assign value  = s_tdata;
	assign full   = occ_vec[DEPTH-1];
	assign empty  = !occ_vec[0];

	// Stage 1 drains into the output register when it is free or being taken
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	// Decide whether the operation applies and what status it reports
	always_comb begin
		cmd.en    = 1'b0;
		cmd.func  = func;
		cmd.value = value;
		status_d  = bdqs_pkg::STATUS_DONE;
		held_d    = held_q;
		case (func)
			bdqs_pkg::FUNC_PUSH_FRONT, bdqs_pkg::FUNC_PUSH_BACK: begin
				if (full) begin
					status_d = bdqs_pkg::STATUS_FULL_DROP;
				end else begin
					cmd.en = accept;
					held_d = held_q + CNT_W'(1);
				end
			end
			bdqs_pkg::FUNC_POP_BACK: begin
				if (empty) begin
					status_d = bdqs_pkg::STATUS_POP_EMPTY;
				end else begin
					cmd.en = accept;
					held_d = held_q - CNT_W'(1);
				end
			end
			default: cmd.en = accept;
		endcase
	end

	// Row of cells, front at index 0
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [bdqs_pkg::VALUE_W-1:0] prev_data;
			logic                         prev_occ;
			logic                         next_occ;
			if (gi == 0) begin : g_first
				assign prev_data = value;
				assign prev_occ  = 1'b1;
			end else begin : g_mid
				assign prev_data = data_vec[gi-1];
				assign prev_occ  = occ_vec[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign next_occ = 1'b0;
			end else begin : g_inner
				assign next_occ = occ_vec[gi+1];
			end
			bdqs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.prev_data (prev_data),
				.prev_occ  (prev_occ),
				.next_occ  (next_occ),
				.data      (data_vec[gi]),
				.occ       (occ_vec[gi]),
				.hit       (hit_vec[gi])
			);
		end
	endgenerate

	// Held count and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) held_q <= held_d;
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			status_s1 <= status_d;
			count_s1  <= held_d;
		end
	end

	// Fit the held count to the 5-bit result field
	generate
		if (CNT_W >= bdqs_pkg::COUNT_W) begin : g_cnt_trunc
			assign count5_s1 = count_s1[bdqs_pkg::COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign count5_s1 = {{(bdqs_pkg::COUNT_W - CNT_W){1'b0}}, count_s1};
		end
	endgenerate

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q  <= (func_s1 == bdqs_pkg::FUNC_SEARCH) && (|hit_vec);
			count_q  <= count5_s1;
			empty_q  <= (count_s1 == '0);
			status_q <= status_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, status_q, empty_q, count_q, found_q};

endmodule

[verif/bounded_deque_with_search_unit_tb.sv]
// Self-checking testbench for bounded_deque_with_search_unit: directed table, then random
// push/pop/search traffic with random stalls on both streams, checked against a local predictor.
// Depends on bdqs_pkg (codes, widths) and the unit under test.
module bounded_deque_with_search_unit_tb;
	import bdqs_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int N_RANDOM    = 1620;
	localparam int N_DIRECTED  = 18;
	localparam int LONG_HOLD   = 90;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 12;

	typedef struct packed {
		logic                found;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic [STATUS_W-1:0] status;
	} deque_reply_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  op;
		logic [VALUE_W-1:0] val;
		logic [4:0]         reps;
		logic               typed;
		deque_reply_t       reply;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] value
	logic [1:0]  s_tuser;  // [1:0] func
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // [0] found, [5:1] count, [6] is_empty, [8:7] status

	bounded_deque_with_search_unit #(.DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predicted deque contents: circular store, front cell and fill level
	logic [VALUE_W-1:0] cells [DEPTH];
	int                 head;
	int                 fill;
	deque_reply_t       reply_q [$];

	int       n_errors;
	int       n_items;
	int       n_replies;
	int       n_full_drops;
	int       n_empty_pops;
	int       n_hits;
	int       peak_fill;
	int       n_long_holds;
	int       n_drains;
	int       idle_cycles;
	bit       long_hold_req;
	bit       send_calm;
	bit       recv_calm;
	dir_row_t dir_tab [N_DIRECTED];

	// Clock: period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Apply one item to the predicted deque and return its reply
	function automatic deque_reply_t deque_apply(input logic [FUNC_W-1:0] op,
			input logic [VALUE_W-1:0] val);
		deque_reply_t r;
		r = '0;
		r.status = STATUS_DONE;
		case (op)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					r.status = STATUS_FULL_DROP;
				end else if (op == FUNC_PUSH_FRONT) begin
					head = (head + DEPTH - 1) % DEPTH;
					cells[head] = val;
					fill++;
				end else begin
					cells[(head + fill) % DEPTH] = val;
					fill++;
				end
			end
			FUNC_POP_BACK: begin
				if (fill == 0)
					r.status = STATUS_POP_EMPTY;
				else
					fill--;
			end
			default: begin
				for (int i = 0; i < fill; i++)
					if (cells[(head + i) % DEPTH] == val)
						r.found = 1'b1;
			end
		endcase
		r.count = fill[COUNT_W-1:0];
		r.is_empty = (fill == 0);
		return r;
	endfunction

	// Idle cycles before the next item; toggle into and out of no-idle stretches
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	// Pick a value: a held entry for a likely hit, else extremes, small values or random bits
	function automatic logic [VALUE_W-1:0] pick_value(input bit want_hit);
		int k;
		k = $urandom_range(0, 7);
		if (want_hit && fill > 0)
			return cells[(head + $urandom_range(0, fill - 1)) % DEPTH];
		case (k)
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3, 4:    return VALUE_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic dir_row_t make_row(input logic [FUNC_W-1:0] op,
			input logic [VALUE_W-1:0] val, input int reps, input bit typed,
			input bit found, input int count, input bit is_empty,
			input logic [STATUS_W-1:0] status);
		dir_row_t row;
		row.op = op;
		row.val = val;
		row.reps = reps[4:0];
		row.typed = typed;
		row.reply.found = found;
		row.reply.count = count[COUNT_W-1:0];
		row.reply.is_empty = is_empty;
		row.reply.status = status;
		return row;
	endfunction

	// Offer one item after a gap; on accept, advance the predictor and queue the reply
	task automatic offer(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val,
			input bit typed, input deque_reply_t typed_reply, input int gap);
		deque_reply_t r;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = val;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		r = deque_apply(op, val);
		if (r.status == STATUS_FULL_DROP)
			n_full_drops++;
		if (r.status == STATUS_POP_EMPTY)
			n_empty_pops++;
		if (r.found)
			n_hits++;
		if (fill > peak_fill)
			peak_fill = fill;
		if (typed)
			r = typed_reply;
		reply_q = {reply_q, r};
		n_items++;
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		int                 phase;
		int                 phase_left;
		int                 burst_left;
		int                 push_pct;
		int                 pop_pct;
		int                 pick;
		int                 gap;
		logic [FUNC_W-1:0]  op;
		logic [VALUE_W-1:0] val;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_PUSH_FRONT;
		head = 0;
		fill = 0;
		n_errors = 0;
		n_items = 0;
		n_full_drops = 0;
		n_empty_pops = 0;
		n_hits = 0;
		peak_fill = 0;
		n_drains = 0;
		long_hold_req = 1'b0;
		send_calm = 1'b0;

		// Directed table: typed replies where they are obvious, predictor elsewhere
		dir_tab[0]  = make_row(FUNC_POP_BACK,   32'h0,         1, 1, 0, 0, 1, STATUS_POP_EMPTY);
		dir_tab[1]  = make_row(FUNC_SEARCH,     32'h0,         1, 1, 0, 0, 1, STATUS_DONE);
		dir_tab[2]  = make_row(FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1, 1, 0, 1, 0, STATUS_DONE);
		dir_tab[3]  = make_row(FUNC_PUSH_FRONT, 32'h8000_0000, 1, 1, 0, 2, 0, STATUS_DONE);
		dir_tab[4]  = make_row(FUNC_SEARCH,     32'h8000_0000, 1, 1, 1, 2, 0, STATUS_DONE);
		dir_tab[5]  = make_row(FUNC_SEARCH,     32'h7FFF_FFFF, 1, 1, 1, 2, 0, STATUS_DONE);
		dir_tab[6]  = make_row(FUNC_SEARCH,     32'hFFFF_FFFF, 1, 1, 0, 2, 0, STATUS_DONE);
		dir_tab[7]  = make_row(FUNC_POP_BACK,   32'hFFFF_FFFF, 1, 1, 0, 1, 0, STATUS_DONE);
		dir_tab[8]  = make_row(FUNC_SEARCH,     32'h8000_0000, 1, 1, 1, 1, 0, STATUS_DONE);
		dir_tab[9]  = make_row(FUNC_POP_BACK,   32'h0,         1, 1, 0, 0, 1, STATUS_DONE);
		dir_tab[10] = make_row(FUNC_PUSH_FRONT, 32'h0000_0001, 1, 0, 0, 0, 0, STATUS_DONE);
		dir_tab[11] = make_row(FUNC_PUSH_FRONT, 32'hAAAA_AAAA, 7, 0, 0, 0, 0, STATUS_DONE);
		dir_tab[12] = make_row(FUNC_PUSH_BACK,  32'h5555_5555, 8, 0, 0, 0, 0, STATUS_DONE);
		dir_tab[13] = make_row(FUNC_PUSH_FRONT, 32'h0,         1, 1, 0, 16, 0, STATUS_FULL_DROP);
		dir_tab[14] = make_row(FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1, 1, 0, 16, 0, STATUS_FULL_DROP);
		dir_tab[15] = make_row(FUNC_SEARCH,     32'h5555_5555, 1, 1, 1, 16, 0, STATUS_DONE);
		dir_tab[16] = make_row(FUNC_SEARCH,     32'h0000_0001, 1, 1, 1, 16, 0, STATUS_DONE);
		dir_tab[17] = make_row(FUNC_SEARCH,     32'h0,         1, 1, 0, 16, 0, STATUS_DONE);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		for (int t = 0; t < N_DIRECTED; t++)
			for (int k = 0; k < dir_tab[t].reps; k++)
				offer(dir_tab[t].op, dir_tab[t].val, dir_tab[t].typed, dir_tab[t].reply,
					draw_gap(send_calm));

		// Random traffic in phases that fill, drain or mix the deque
		phase = 0;
		phase_left = 0;
		burst_left = 0;
		push_pct = 0;
		pop_pct = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			// Ask the receiver to hold off while the sender keeps offering
			if (n == 400 || n == 1200) begin
				long_hold_req = 1'b1;
				burst_left = 60;
			end
			// Pause the sender until every pending reply has drained
			if (n == 800 || (phase_left == 0 && $urandom_range(0, 3) == 0)) begin
				s_tvalid = 1'b0;
				while (reply_q.size() != 0)
					@(negedge clk);
				n_drains++;
			end
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 80);
				case (phase)
					0:       begin push_pct = 70; pop_pct = 10; end
					1:       begin push_pct = 15; pop_pct = 65; end
					default: begin push_pct = 35; pop_pct = 30; end
				endcase
			end
			phase_left--;

			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				op = ($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
			else if (pick < push_pct + pop_pct)
				op = FUNC_POP_BACK;
			else
				op = FUNC_SEARCH;
			val = pick_value(op == FUNC_SEARCH && $urandom_range(0, 1) != 0);

			if (burst_left > 0) begin
				burst_left--;
				gap = 0;
			end else begin
				gap = draw_gap(send_calm);
			end
			offer(op, val, 1'b0, '0, gap);
		end

		// Drain and let any stray reply show up
		s_tvalid = 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d items, %0d replies: %0d full drops, %0d pops on empty, %0d hits",
			n_items, n_replies, n_full_drops, n_empty_pops, n_hits);
		$display("peak fill %0d of %0d, %0d long receiver holds, %0d sender drains",
			peak_fill, DEPTH, n_long_holds, n_drains);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver: random stall per reply, long hold on request
	initial begin
		int wait_n;
		m_tready = 1'b0;
		n_long_holds = 0;
		recv_calm = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				n_long_holds++;
				wait_n = LONG_HOLD;
			end else begin
				wait_n = draw_gap(recv_calm);
			end
			if (wait_n > 0) begin
				m_tready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Reply checker
	initial begin
		deque_reply_t got;
		deque_reply_t want;
		n_replies = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.found = m_tdata[0];
				got.count = m_tdata[5:1];
				got.is_empty = m_tdata[6];
				got.status = m_tdata[8:7];
				n_replies++;
				if (m_tdata[15:9] !== '0) begin
					$display("%0t: pad bits expected 0 got %h", $time, m_tdata[15:9]);
					n_errors++;
				end
				if (reply_q.size() == 0) begin
					$display("%0t: reply with none pending, got %h", $time, m_tdata);
					n_errors++;
				end else begin
					want = reply_q.pop_front();
					if (got !== want) begin
						$display("%0t: reply %0d mismatch: found exp %0d got %0d,",
							$time, n_replies, want.found, got.found,
							" count exp %0d got %0d,", want.count, got.count,
							" empty exp %0d got %0d,", want.is_empty, got.is_empty,
							" status exp %0d got %0d", want.status, got.status);
						n_errors++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either stream for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles, %0d replies pending",
			$time, STALL_LIMIT, reply_q.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
